@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, command codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned ExpW  = 16;

  typedef logic [Width-1:0] word_t;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;
  localparam logic [2:0] CmdAbs = 3'd4;
  localparam logic [2:0] CmdRed = 3'd5;
  localparam logic [2:0] CmdPow = 3'd6;

  // Operand pair selection for a multiply step.
  localparam logic [2:0] MulAnBd = 3'd0; // x = an*bd
  localparam logic [2:0] MulAdBd = 3'd1; // d = ad*bd
  localparam logic [2:0] MulAnBn = 3'd2; // n = an*bn
  localparam logic [2:0] MulAdBn = 3'd3; // d = ad*bn
  localparam logic [2:0] MulBnAd = 3'd4; // n = bn*ad

  // Datapath operations issued by the controller.
  localparam logic [3:0] OpNone    = 4'd0;
  localparam logic [3:0] OpLoad    = 4'd1;
  localparam logic [3:0] OpMulN    = 4'd2;  // n <= product of selected pair
  localparam logic [3:0] OpMulD    = 4'd3;
  localparam logic [3:0] OpMulX    = 4'd4;  // x <= product
  localparam logic [3:0] OpAddXN   = 4'd5;  // n <= x + n
  localparam logic [3:0] OpSubXN   = 4'd6;
  localparam logic [3:0] OpAbs     = 4'd7;
  localparam logic [3:0] OpRedInit = 4'd8;  // sign move, set up gcd
  localparam logic [3:0] OpGcdStep = 4'd9;  // one remainder bit
  localparam logic [3:0] OpGcdNext = 4'd10; // a<=b, b<=rem
  localparam logic [3:0] OpDivInit = 4'd11; // start dividing n and d by g
  localparam logic [3:0] OpQStep   = 4'd12;
  localparam logic [3:0] OpQDone   = 4'd13;
  localparam logic [3:0] OpPowSet  = 4'd14; // store / commit pow operands
  localparam logic [3:0] OpZero    = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;   // MulXX code, or sub-operation for OpPowSet
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;  // reduction target has zero denominator
    logic gcd_zero;  // gcd b register is zero
    logic cnt_done;  // bit counter finished
  } dp_sts_t;

  // OpPowSet sub-operations; the base is kept in bn/bd throughout.
  localparam logic [2:0] PsInit    = 3'd0; // res<=1/1, base<=a
  localparam logic [2:0] PsResMul  = 3'd1; // operands: res*base
  localparam logic [2:0] PsBaseSq  = 3'd2; // operands: base*base
  localparam logic [2:0] PsSaveRes = 3'd3; // res <= n/d
  localparam logic [2:0] PsSaveBas = 3'd4; // base <= n/d
  localparam logic [2:0] PsInv     = 3'd5; // operands: 1/1 over res
  localparam logic [2:0] PsOutRes  = 3'd6; // n/d <= res

endpackage

`default_nettype wire

@@ hw/rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, a 32x32 product with magnitude overflow check, adder,
// subtractor, and a bit-serial divider for gcd remainders and exact divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath import rau_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dp_cmd_t         cmd_i,
  input  wire logic [31:0]     a_num_i,
  input  wire logic [31:0]     a_den_i,
  input  wire logic [31:0]     b_num_i,
  input  wire logic [31:0]     b_den_i,
  output dp_sts_t              sts_o,
  output logic [31:0]          res_num_o,
  output logic [31:0]          res_den_o,
  output logic                 overflow_o
);

  localparam logic [Width-1:0] SignBit = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] One     = {{(Width-1){1'b0}}, 1'b1};
  localparam int unsigned      CntW    = $clog2(Width + 1);

  word_t an_q, ad_q, bn_q, bd_q, n_q, d_q, x_q, rn_q, rd_q;
  word_t ga_q, gb_q, rem_q, quo_q, dvd_q;
  logic  ovf_q, qsel_q, nneg_q;
  logic  [CntW-1:0] cnt_q;

  // Width conversion of a 32-bit signed input.
  function automatic word_t ext(input logic [31:0] v);
    logic [63:0] t;
    t = {{32{v[31]}}, v};
    return t[Width-1:0];
  endfunction

  function automatic word_t magn(input word_t v);
    return v[Width-1] ? (~v + One) : v;
  endfunction

  // Multiplier operand selection.
  word_t mx, my;
  always_comb begin
    case (cmd_i.sel)
      MulAnBd: begin mx = an_q; my = bd_q; end
      MulAdBd: begin mx = ad_q; my = bd_q; end
      MulAnBn: begin mx = an_q; my = bn_q; end
      MulAdBn: begin mx = ad_q; my = bn_q; end
      MulBnAd: begin mx = bn_q; my = ad_q; end
      default: begin mx = bn_q; my = ad_q; end
    endcase
  end

  // Product and its overflow: magnitude product against the signed limit.
  word_t ma, mb, prod;
  logic [2*Width-1:0] mprod;
  logic mneg, movf;
  always_comb begin
    ma    = magn(mx);
    mb    = magn(my);
    mneg  = mx[Width-1] ^ my[Width-1];
    mprod = {{Width{1'b0}}, ma} * {{Width{1'b0}}, mb};
    prod  = mx * my;
    if (ma == '0 || mb == '0) movf = 1'b0;
    else if (mneg) movf = mprod > {{Width{1'b0}}, SignBit};
    else movf = mprod > {{Width{1'b0}}, SignBit - One};
  end

  // Sum and difference of x and n.
  word_t sum, dif;
  always_comb begin
    sum = x_q + n_q;
    dif = x_q - n_q;
  end

  // One restoring-division bit: remainder shift and trial subtract.
  logic [Width:0] rsh, rtr;
  word_t divisor;
  always_comb begin
    divisor = (cmd_i.op == OpQStep) ? ga_q : gb_q;
    rsh = {rem_q, dvd_q[Width-1]};
    rtr = rsh - {1'b0, divisor};
  end

  always_comb begin
    sts_o.den_zero = (d_q == '0);
    sts_o.gcd_zero = (gb_q == '0);
    sts_o.cnt_done = (cnt_q == CntW'(Width));
  end

  // Control flags of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        OpLoad:    ovf_q <= 1'b0;
        OpMulN, OpMulD, OpMulX: ovf_q <= ovf_q | movf;
        OpAddXN:   ovf_q <= ovf_q | ((x_q[Width-1] ~^ n_q[Width-1]) &
                                     (sum[Width-1] ^ x_q[Width-1]));
        OpSubXN:   ovf_q <= ovf_q | ((x_q[Width-1] ^ n_q[Width-1]) &
                                     (dif[Width-1] ^ x_q[Width-1]));
        OpAbs:     ovf_q <= ovf_q | (n_q == SignBit) | (d_q == SignBit);
        OpRedInit: ovf_q <= ovf_q | (d_q[Width-1] &
                                     ((n_q == SignBit) | (d_q == SignBit)));
        OpZero:    ovf_q <= 1'b0;
        default:   ovf_q <= ovf_q;
      endcase
      case (cmd_i.op)
        OpGcdNext, OpDivInit, OpQDone: cnt_q <= '0;
        OpGcdStep, OpQStep:            cnt_q <= cnt_q + CntW'(1);
        default:                       cnt_q <= cnt_q;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        an_q <= ext(a_num_i); ad_q <= ext(a_den_i);
        bn_q <= ext(b_num_i); bd_q <= ext(b_den_i);
        n_q  <= ext(a_num_i); d_q  <= ext(a_den_i);
      end
      OpMulN: n_q <= prod;
      OpMulD: d_q <= prod;
      OpMulX: x_q <= prod;
      OpAddXN: n_q <= sum;
      OpSubXN: n_q <= dif;
      OpAbs: begin
        n_q <= n_q[Width-1] ? ~n_q + One : n_q;
        d_q <= d_q[Width-1] ? ~d_q + One : d_q;
      end
      OpRedInit: begin
        if (d_q[Width-1]) begin
          n_q <= ~n_q + One;
          d_q <= ~d_q + One;
          ga_q <= magn(~n_q + One);
          gb_q <= magn(~d_q + One);
          dvd_q <= magn(~n_q + One);
        end else begin
          ga_q <= magn(n_q);
          gb_q <= magn(d_q);
          dvd_q <= magn(n_q);
        end
        rem_q <= '0;
      end
      OpGcdStep, OpQStep: begin
        if (!rtr[Width]) begin
          rem_q <= rtr[Width-1:0];
          quo_q <= {quo_q[Width-2:0], 1'b1};
        end else begin
          rem_q <= rsh[Width-1:0];
          quo_q <= {quo_q[Width-2:0], 1'b0};
        end
        dvd_q <= {dvd_q[Width-2:0], 1'b0};
      end
      OpGcdNext: begin
        ga_q  <= gb_q;
        gb_q  <= rem_q;
        dvd_q <= gb_q;
        rem_q <= '0;
      end
      // ga holds the gcd; divide |n| first, then |d|.
      OpDivInit: begin
        dvd_q  <= magn(n_q);
        nneg_q <= n_q[Width-1];
        rem_q  <= '0;
        qsel_q <= 1'b0;
      end
      OpQDone: begin
        if (!qsel_q) begin
          n_q    <= nneg_q ? ~quo_q + One : quo_q;
          dvd_q  <= magn(d_q);
          nneg_q <= d_q[Width-1];
          qsel_q <= 1'b1;
        end else begin
          d_q <= nneg_q ? ~quo_q + One : quo_q;
        end
        rem_q <= '0;
      end
      // The power loop keeps the running result in rn/rd and the base in bn/bd.
      OpPowSet: begin
        case (cmd_i.sel)
          PsInit: begin
            rn_q <= One; rd_q <= One; bn_q <= an_q; bd_q <= ad_q;
          end
          PsResMul:  begin an_q <= rn_q; ad_q <= rd_q; end
          PsBaseSq:  begin an_q <= bn_q; ad_q <= bd_q; end
          PsSaveRes: begin rn_q <= n_q; rd_q <= d_q; end
          PsSaveBas: begin bn_q <= n_q; bd_q <= d_q; end
          PsInv: begin an_q <= One; ad_q <= One; bn_q <= rn_q; bd_q <= rd_q; end
          PsOutRes:  begin n_q <= rn_q; d_q <= rd_q; end
          default:   ;
        endcase
      end
      OpZero: begin n_q <= '0; d_q <= '0; end
      default: ;
    endcase
  end

  assign res_num_o  = 32'(n_q);
  assign res_den_o  = 32'(d_q);
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

@@ hw/rtl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences multiplies, gcd reduction and the square-and-multiply loop.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl import rau_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [2:0]      cmd_i,
  input  wire logic [15:0]     exponent_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire dp_sts_t         sts_i,
  output dp_cmd_t              dp_o
);

  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SAs1    = 5'd1;   // x = an*bd
  localparam logic [4:0] SAs2    = 5'd2;   // n = bn*ad
  localparam logic [4:0] SAs3    = 5'd3;   // n = x +/- n
  localparam logic [4:0] SMulN   = 5'd4;
  localparam logic [4:0] SMulD   = 5'd5;
  localparam logic [4:0] SAbs    = 5'd6;
  localparam logic [4:0] SRed    = 5'd7;
  localparam logic [4:0] SGcd    = 5'd8;
  localparam logic [4:0] SGcdNx  = 5'd9;
  localparam logic [4:0] SQInit  = 5'd10;
  localparam logic [4:0] SQ      = 5'd11;
  localparam logic [4:0] SQDone  = 5'd12;
  localparam logic [4:0] SRedEnd = 5'd13;
  localparam logic [4:0] SPowBit = 5'd14;
  localparam logic [4:0] SPowSq  = 5'd15;
  localparam logic [4:0] SPowLd  = 5'd16;
  localparam logic [4:0] SOut    = 5'd17;
  localparam logic [4:0] SZero   = 5'd18;

  // Where a reduction returns to in the power loop.
  localparam logic [1:0] RetOut  = 2'd0;
  localparam logic [1:0] RetRes  = 2'd1;
  localparam logic [1:0] RetBase = 2'd2;

  logic [4:0]  st_q, st_d;
  logic [2:0]  op_q, op_d;
  logic [15:0] p_q, p_d;
  logic        eneg_q, eneg_d, inv_q, inv_d, qh_q, qh_d;
  logic [1:0]  ret_q, ret_d;
  logic [2:0]  msel_q, msel_d;

  always_comb begin
    st_d = st_q; op_d = op_q; p_d = p_q; eneg_d = eneg_q; inv_d = inv_q;
    qh_d = qh_q; ret_d = ret_q; msel_d = msel_q;
    dp_o.op = OpNone; dp_o.sel = msel_q;
    in_ready_o  = (st_q == SIdle);
    out_valid_o = (st_q == SOut);
    case (st_q)
      SIdle: if (in_valid_i) begin
        dp_o.op = OpLoad;
        op_d = cmd_i; ret_d = RetOut; inv_d = 1'b0;
        eneg_d = exponent_i[15];
        p_d = exponent_i[15] ? 16'(~exponent_i + 16'd1) : exponent_i;
        case (cmd_i)
          CmdAdd, CmdSub: st_d = SAs1;
          CmdMul: begin msel_d = MulAnBn; st_d = SMulN; end
          CmdDiv: begin msel_d = MulAnBd; st_d = SMulN; end
          CmdAbs: st_d = SAbs;
          CmdRed: st_d = SRed;
          CmdPow: st_d = SPowLd;
          default: st_d = SZero;
        endcase
      end
      SAs1: begin dp_o.op = OpMulX; dp_o.sel = MulAnBd; st_d = SAs2; end
      SAs2: begin dp_o.op = OpMulN; dp_o.sel = MulBnAd; st_d = SAs3; end
      SAs3: begin
        dp_o.op = (op_q == CmdSub) ? OpSubXN : OpAddXN;
        msel_d = MulAdBd; st_d = SMulD;
      end
      SMulN: begin
        dp_o.op = OpMulN;
        msel_d = (msel_q == MulAnBd) ? MulAdBn : MulAdBd;
        st_d = SMulD;
      end
      SMulD: begin dp_o.op = OpMulD; st_d = SRed; end
      SAbs:  begin dp_o.op = OpAbs; st_d = SRed; end
      SRed: begin
        if (sts_i.den_zero) st_d = SRedEnd;
        else begin dp_o.op = OpRedInit; st_d = SGcd; end
      end
      SGcd: begin
        if (sts_i.gcd_zero) st_d = SQInit;
        else if (sts_i.cnt_done) st_d = SGcdNx;
        else dp_o.op = OpGcdStep;
      end
      SGcdNx: begin dp_o.op = OpGcdNext; st_d = SGcd; end
      SQInit: begin dp_o.op = OpDivInit; qh_d = 1'b0; st_d = SQ; end
      SQ: begin
        if (sts_i.cnt_done) st_d = SQDone;
        else dp_o.op = OpQStep;
      end
      SQDone: begin
        dp_o.op = OpQDone;
        if (!qh_q) begin qh_d = 1'b1; st_d = SQ; end
        else st_d = SRedEnd;
      end
      SRedEnd: begin
        case (ret_q)
          RetRes: begin
            dp_o.op = OpPowSet; dp_o.sel = PsSaveRes;
            st_d = (p_q == '0) ? SPowLd : SPowSq;
          end
          RetBase: begin
            // n/d now hold the new base; store it and loop on the next bit
            dp_o.op = OpPowSet; dp_o.sel = PsSaveBas;
            st_d = SPowBit;
          end
          default: st_d = SOut;
        endcase
      end
      // First entry: res = 1/1, base taken from a. Re-entry after the last bit.
      SPowLd: begin
        if (ret_q == RetOut && op_q == CmdPow && !inv_q) begin
          dp_o.op = OpPowSet; dp_o.sel = PsInit;
          inv_d = 1'b1;
          if (p_q == '0) begin st_d = SPowSq; ret_d = RetOut; end
          else begin st_d = SPowBit; ret_d = RetBase; end
        end else begin
          // finished: optional inversion
          if (eneg_q) begin
            dp_o.op = OpPowSet; dp_o.sel = PsInv;
            eneg_d = 1'b0; ret_d = RetOut;
            msel_d = MulAnBd; st_d = SMulN;
          end else begin
            dp_o.op = OpPowSet; dp_o.sel = PsOutRes; st_d = SOut;
          end
        end
      end
      SPowBit: begin
        if (p_q[0]) begin
          dp_o.op = OpPowSet; dp_o.sel = PsResMul;
          ret_d = RetRes; msel_d = MulAnBn; st_d = SMulN;
        end else st_d = SPowSq;
        p_d = p_q >> 1;
      end
      SPowSq: begin
        if (ret_q == RetOut) begin
          // exponent zero: the result stays at 1/1
          st_d = SPowLd;
          eneg_d = 1'b0;
        end else if (p_q == '0) st_d = SPowLd;
        else begin
          dp_o.op = OpPowSet; dp_o.sel = PsBaseSq;
          ret_d = RetBase; msel_d = MulAnBn; st_d = SMulN;
        end
      end
      SOut: if (out_ready_i) st_d = SIdle;
      SZero: begin dp_o.op = OpZero; st_d = SOut; end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; op_q <= '0; p_q <= '0; eneg_q <= 1'b0; inv_q <= 1'b0;
      qh_q <= 1'b0; ret_q <= RetOut; msel_q <= '0;
    end else begin
      st_q <= st_d; op_q <= op_d; p_q <= p_d; eneg_q <= eneg_d; inv_q <= inv_d;
      qh_q <= qh_d; ret_q <= ret_d; msel_q <= msel_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply, divide, absolute, reduce and power.
// ----------------------------------------------------------------------------
// One request at a time: the input is ready only while the unit is idle and
// the result is held until it is taken. Each reduction runs Euclid's
// algorithm on a bit-serial divider, followed by two exact divisions; a
// power operation repeats a multiply and a reduction for every exponent
// bit. A zero denominator skips the reduction.
`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  input  wire logic [15:0] exponent_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      res_num_o,
  output logic [31:0]      res_den_o,
  output logic             overflow_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .exponent_i,
    .out_valid_o, .out_ready_i, .sts_i(dp_sts), .dp_o(dp_cmd)
  );

  // Arithmetic.
  rau_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .sts_o(dp_sts), .res_num_o, .res_den_o, .overflow_o
  );

endmodule

`default_nettype wire

@@ hw/rtl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on the request handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] res_num_o,
  input wire logic [31:0] res_den_o
);

  // A result that waits keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_num_o)
    && $stable(res_den_o)) else $error("result changed while stalled");

  // Only one request is in flight.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // An accepted request does not produce a result in the next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o) else $error("result too early");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

`default_nettype wire
